FILE: design/swrc_pkg.sv
package swrc_pkg;

   localparam int FLAG_IN_USE_BIT = 0;

   localparam logic [15:0] ONES_SUM_TARGET = 16'hffff;

   // reply flag words: in-use plus ack, in-use plus nack
   localparam logic [6:0] REPLY_FLAGS_ACK  = 7'd5;
   localparam logic [6:0] REPLY_FLAGS_NACK = 7'd65;

   typedef enum logic [1:0] {
      VERDICT_NEW = 2'd0,
      VERDICT_DUP = 2'd1,
      VERDICT_BAD = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [15:0] seq_num;
      logic        sum_ok;
   } check_type;

   // fold a sum of up to sixteen words to 16 bits with end-around carry
   function automatic logic [15:0] fold20(input logic [19:0] s);
      logic [16:0] s1;
      logic [15:0] s2;
      s1 = {13'd0, s[19:16]} + {1'b0, s[15:0]};
      s2 = s1[15:0] + {15'd0, s1[16]};
      return s2;
   endfunction

   function automatic logic [15:0] reply_sum(input logic [15:0] ack, input logic [6:0] flags);
      logic [16:0] s;
      logic [15:0] f;
      s = {1'b0, ack} + {10'd0, flags};
      // flags are small, one carry wrap is enough
      f = s[15:0] + {15'd0, s[16]};
      return ~f;
   endfunction

endpackage

FILE: design/swrc_if.sv
interface swrc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] seq_num;
   logic [15:0] ack_num;
   logic [15:0] flag_bits;
   logic [15:0] pkt_count;
   logic [15:0] hdr_checksum;

   modport source(output valid, src_addr, dst_addr, src_port, dst_port, seq_num, ack_num,
                  flag_bits, pkt_count, hdr_checksum, input ready);
   modport sink(input valid, src_addr, dst_addr, src_port, dst_port, seq_num, ack_num,
                flag_bits, pkt_count, hdr_checksum, output ready);
   modport monitor(input valid, ready, src_addr, dst_addr, src_port, dst_port, seq_num,
                   ack_num, flag_bits, pkt_count, hdr_checksum);
endinterface

interface swrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [15:0] reply_ack;
   logic [6:0]  reply_flags;
   logic [15:0] reply_checksum;

   modport source(output valid, verdict, reply_ack, reply_flags, reply_checksum,
                  input ready);
   modport sink(input valid, verdict, reply_ack, reply_flags, reply_checksum,
                output ready);
   modport monitor(input valid, ready, verdict, reply_ack, reply_flags, reply_checksum);
endinterface

FILE: design/swrc_hdr_check.sv
module swrc_hdr_check (
   input  logic                clock,
   input  logic                reset,
   swrc_req_if.sink            req_chan,
   input  logic                check_ready,
   output logic                check_valid,
   output swrc_pkg::check_type check_data
);
   import swrc_pkg::*;

   logic        hdr_valid_ff, hdr_valid_in;
   logic [31:0] src_addr_ff, dst_addr_ff;
   logic [15:0] src_port_ff, dst_port_ff, seq_num_ff, ack_num_ff;
   logic [15:0] flag_bits_ff, pkt_count_ff, hdr_checksum_ff;

   logic        chk_valid_ff, chk_valid_in;
   check_type   check_ff, check_in;

   logic        stage_ready, hdr_ready, accept;
   logic [19:0] word_sum;
   logic [15:0] folded;
   logic [16:0] total;

   assign stage_ready    = !chk_valid_ff || check_ready;
   assign hdr_ready      = !hdr_valid_ff || stage_ready;
   assign req_chan.ready = hdr_ready;
   assign accept         = req_chan.valid && hdr_ready;

   // a request without the in-use flag is taken and dropped here
   always_comb begin
      if (accept) begin
         hdr_valid_in = req_chan.flag_bits[FLAG_IN_USE_BIT];
      end else begin
         hdr_valid_in = hdr_valid_ff && !stage_ready;
      end
   end

   always_comb begin
      word_sum = {4'd0, src_addr_ff[15:0]} + {4'd0, src_addr_ff[31:16]}
               + {4'd0, dst_addr_ff[15:0]} + {4'd0, dst_addr_ff[31:16]}
               + {4'd0, src_port_ff} + {4'd0, dst_port_ff}
               + {4'd0, seq_num_ff} + {4'd0, ack_num_ff}
               + {4'd0, flag_bits_ff} + {4'd0, pkt_count_ff};
      folded   = fold20(word_sum);
      // compare without wrap
      total    = {1'b0, folded} + {1'b0, hdr_checksum_ff};
      check_in.seq_num = seq_num_ff;
      check_in.sum_ok  = (total == {1'b0, ONES_SUM_TARGET});
   end

   assign chk_valid_in = stage_ready ? hdr_valid_ff : chk_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         hdr_valid_ff <= hdr_valid_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_addr_ff     <= req_chan.src_addr;
         dst_addr_ff     <= req_chan.dst_addr;
         src_port_ff     <= req_chan.src_port;
         dst_port_ff     <= req_chan.dst_port;
         seq_num_ff      <= req_chan.seq_num;
         ack_num_ff      <= req_chan.ack_num;
         flag_bits_ff    <= req_chan.flag_bits;
         pkt_count_ff    <= req_chan.pkt_count;
         hdr_checksum_ff <= req_chan.hdr_checksum;
      end
      if (stage_ready) begin
         check_ff <= check_in;
      end
   end

   assign check_valid = chk_valid_ff;
   assign check_data  = check_ff;

endmodule

FILE: design/swrc_reply.sv
module swrc_reply (
   input  logic                clock,
   input  logic                reset,
   input  logic                check_valid,
   input  swrc_pkg::check_type check_data,
   output logic                check_ready,
   swrc_rsp_if.source          rsp_chan
);
   import swrc_pkg::*;

   logic [15:0] last_seq_ff, last_seq_in;
   logic [15:0] pending_ack_ff, pending_ack_in;
   logic        nack_mode_ff, nack_mode_in;

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   logic [15:0] reply_ack_ff, reply_ack_in;
   logic [6:0]  reply_flags_ff, reply_flags_in;
   logic [15:0] reply_checksum_ff, reply_checksum_in;

   logic        take;

   assign check_ready = !rsp_valid_ff || rsp_chan.ready;
   assign take        = check_valid && check_ready;

   always_comb begin
      last_seq_in    = last_seq_ff;
      pending_ack_in = pending_ack_ff;
      nack_mode_in   = nack_mode_ff;
      reply_flags_in = nack_mode_ff ? REPLY_FLAGS_NACK : REPLY_FLAGS_ACK;
      if (check_data.seq_num == last_seq_ff) begin
         verdict_in     = VERDICT_DUP;
         // a duplicate is answered with ack 0 if the last sequence is 1, else with ack 1
         pending_ack_in = (last_seq_ff == 16'd1) ? 16'd0 : 16'd1;
         reply_ack_in   = pending_ack_in;
      end else if (check_data.sum_ok) begin
         verdict_in     = VERDICT_NEW;
         last_seq_in    = check_data.seq_num;
         reply_ack_in   = check_data.seq_num;
         pending_ack_in = 16'd0;
         nack_mode_in   = 1'b0;
      end else begin
         verdict_in     = VERDICT_BAD;
         nack_mode_in   = 1'b1;
         reply_ack_in   = pending_ack_ff;
         reply_flags_in = REPLY_FLAGS_NACK;
      end
      reply_checksum_in = reply_sum(reply_ack_in, reply_flags_in);
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         last_seq_ff    <= 16'd0;
         pending_ack_ff <= 16'd0;
         nack_mode_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            last_seq_ff    <= last_seq_in;
            pending_ack_ff <= pending_ack_in;
            nack_mode_ff   <= nack_mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff        <= verdict_in;
         reply_ack_ff      <= reply_ack_in;
         reply_flags_ff    <= reply_flags_in;
         reply_checksum_ff <= reply_checksum_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = verdict_ff;
   assign rsp_chan.reply_ack      = reply_ack_ff;
   assign rsp_chan.reply_flags    = reply_flags_ff;
   assign rsp_chan.reply_checksum = reply_checksum_ff;

endmodule

FILE: design/stop_wait_receiver_check_unit.sv
// a reply is offered once its request has passed the input, check and reply registers
// throughput: one request per cycle while replies are not stalled, set by the input, check and reply registers
// requests with the in-use flag clear are taken and give no reply
// reset clears the stage valid bits, the last sequence, the pending ack and nack mode
module stop_wait_receiver_check_unit (
   input  logic       clock,
   input  logic       reset,
   swrc_req_if.sink   req_chan,
   swrc_rsp_if.source rsp_chan
);
   import swrc_pkg::*;

   logic      check_valid;
   logic      check_ready;
   check_type check_data;

   swrc_hdr_check u_hdr_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .check_ready (check_ready),
      .check_valid (check_valid),
      .check_data  (check_data)
   );

   swrc_reply u_reply (
      .clock       (clock),
      .reset       (reset),
      .check_valid (check_valid),
      .check_data  (check_data),
      .check_ready (check_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: design/swrc_checker.sv
module swrc_checker (
   input logic        clock,
   input logic        reset,
   swrc_req_if.sink   req_chan,
   swrc_rsp_if.source rsp_chan
);
   import swrc_pkg::*;

   // a stalled reply holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.reply_ack)
         && $stable(rsp_chan.verdict) && $stable(rsp_chan.reply_flags))
      else $error("reply changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("reply valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.reply_checksum
         == reply_sum(rsp_chan.reply_ack, rsp_chan.reply_flags))
      else $error("reply checksum mismatch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.verdict == VERDICT_BAD |->
         rsp_chan.reply_flags == REPLY_FLAGS_NACK)
      else $error("failed check without nack flags");

   // a duplicate is answered with ack 0 or 1
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.verdict == VERDICT_DUP |-> rsp_chan.reply_ack <= 16'd1)
      else $error("duplicate reply with an ack other than 0 or 1");

endmodule

bind stop_wait_receiver_check_unit swrc_checker u_swrc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
